>>> design/hash_join_count_checksum_core_assert.svh
// Assertion macros for the hash join core.
// Depends on nothing; taken in by the core, which checks its own logic.
`ifndef HASH_JOIN_COUNT_CHECKSUM_CORE_ASSERT_SVH
`define HASH_JOIN_COUNT_CHECKSUM_CORE_ASSERT_SVH

// Condition holds in the same cycle
`define HJCC_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hjcc check failed");

// Condition holds in the next cycle
`define HJCC_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hjcc check failed");

`endif

>>> design/hjcc_pkg.sv
// Shared constants and types of the hash join core.
// Depends on nothing; used by the table, the interfaces' users and the top level.
package hjcc_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam logic [63:0] GOLDEN     = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_A      = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_B      = 64'h94d049bb133111eb;
    localparam logic [31:0] HOME_MUL   = 32'h9E3779B1;
    localparam logic [31:0] HOME_SCALE = 32'(TABLE_ENTRIES);
    localparam logic [31:0] COUNT_MAX  = 32'hFFFFFFFF;

    localparam logic [1:0] OP_BUILD = 2'd0;
    localparam logic [1:0] OP_PROBE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [31:0] count;
    } slot_t;

    typedef struct packed {
        logic  en;
        idx_t  addr;
        slot_t data;
    } tbl_wr_t;

endpackage

>>> design/hjcc_if.sv
// Handshake channels of the hash join core: request and response beats.
// Depends on nothing.
interface hjcc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] join_key;

    modport source (output valid, opcode, join_key, input ready);
    modport sink (input valid, opcode, join_key, output ready);
endinterface

interface hjcc_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] multiplicity;
    logic [63:0] match_total;
    logic [63:0] sum_plain;
    logic [63:0] sum_salted;
    logic        table_full;

    modport source (output valid, multiplicity, match_total, sum_plain, sum_salted,
                    table_full, input ready);
    modport sink (input valid, multiplicity, match_total, sum_plain, sum_salted,
                  table_full, output ready);
endinterface

>>> design/hash_join_count_checksum_core.sv
// Hash join build/probe engine: table sequencer, checksum datapath, output register.
// Depends on hjcc_pkg, hjcc_if, hjcc_mul, hjcc_table and the assertion header.
//
// One request beat at a time; req.ready is high only while the engine is idle, and a
// finished response may wait in its output register while the next request is taken.
// Each request runs through the slot memory and the one shared 32x32 multiplier:
// home-slot hashing, a read and a compare per slot visited by linear probing, then the
// hand-over of the result; a probe hit adds the two splitmix64 checksums (six 32x32
// products each, then two for the weighting by multiplicity). A clear sweeps all 1024
// slots, one a cycle, before it answers; the same sweep runs after reset, with req.ready low.
`include "hash_join_count_checksum_core_assert.svh"

module hash_join_count_checksum_core (
    input logic        clk,
    input logic        rst_n,
    hjcc_req_if.sink   req,
    hjcc_rsp_if.source rsp
);
    import hjcc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_HASH0 = 4'd2;
    localparam logic [3:0] ST_HASH1 = 4'd3;
    localparam logic [3:0] ST_HASH2 = 4'd4;
    localparam logic [3:0] ST_READ  = 4'd5;
    localparam logic [3:0] ST_CMP   = 4'd6;
    localparam logic [3:0] ST_MIXI  = 4'd7;
    localparam logic [3:0] ST_MIX   = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    localparam idx_t             IDX_LAST  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(TABLE_ENTRIES - 1);

    // control state
    logic [3:0]       state_reg, state_next;
    idx_t             idx_reg, idx_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [3:0]       st_reg, st_next;
    logic             sel_reg, sel_next;
    logic             clr_reply_reg, clr_reply_next;
    logic             out_valid_reg, out_valid_next;
    logic [63:0]      macc_reg, macc_next;
    logic [63:0]      pacc_reg, pacc_next;
    logic [63:0]      sacc_reg, sacc_next;

    // payload
    logic [1:0]  op_reg, op_next;
    logic [63:0] key_reg, key_next;
    logic [31:0] mult_reg, mult_next;
    logic        full_reg, full_next;
    logic [63:0] w_reg, w_next;
    logic [63:0] r_reg, r_next;
    logic [31:0] om_reg, om_next;
    logic [63:0] ot_reg, ot_next;
    logic [63:0] op_sum_reg, op_sum_next;
    logic [63:0] os_sum_reg, os_sum_next;
    logic        of_reg, of_next;

    // shared units
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    slot_t       rd_data;
    tbl_wr_t     tbl_wr;

    // datapath helpers
    logic [31:0] hi_sum;
    logic [63:0] rr;
    logic [63:0] mix_x;
    logic [63:0] mix_z;
    logic [31:0] sat_cnt;
    logic        load_out;

    hjcc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    hjcc_table u_table (
        .clk     (clk),
        .rd_addr (idx_reg),
        .rd_data (rd_data),
        .wr      (tbl_wr)
    );

    assign hi_sum  = r_reg[63:32] + prod[31:0];
    assign rr      = {hi_sum, r_reg[31:0]};
    assign mix_x   = key_reg ^ (sel_reg ? GOLDEN : 64'd0);
    assign mix_z   = mix_x + GOLDEN;
    assign sat_cnt = (rd_data.count == COUNT_MAX) ? COUNT_MAX : rd_data.count + 32'd1;

    // multiplier operand selection
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            ST_HASH0:
            begin
                mul_a = key_reg[31:0] ^ key_reg[63:32];
                mul_b = HOME_MUL;
            end
            ST_HASH1:
            begin
                mul_a = prod[31:0];
                mul_b = HOME_SCALE;
            end
            ST_MIX:
            begin
                case (st_reg)
                    4'd0:
                    begin
                        mul_a = w_reg[31:0];
                        mul_b = MIX_A[31:0];
                    end
                    4'd1:
                    begin
                        mul_a = w_reg[31:0];
                        mul_b = MIX_A[63:32];
                    end
                    4'd2:
                    begin
                        mul_a = w_reg[63:32];
                        mul_b = MIX_A[31:0];
                    end
                    4'd4:
                    begin
                        mul_a = w_reg[31:0];
                        mul_b = MIX_B[31:0];
                    end
                    4'd5:
                    begin
                        mul_a = w_reg[31:0];
                        mul_b = MIX_B[63:32];
                    end
                    4'd6:
                    begin
                        mul_a = w_reg[63:32];
                        mul_b = MIX_B[31:0];
                    end
                    4'd8:
                    begin
                        mul_a = w_reg[31:0];
                        mul_b = mult_reg;
                    end
                    4'd9:
                    begin
                        mul_a = w_reg[63:32];
                        mul_b = mult_reg;
                    end
                    default:
                    begin
                        mul_a = 32'd0;
                        mul_b = 32'd0;
                    end
                endcase
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        st_next        = st_reg;
        sel_next       = sel_reg;
        clr_reply_next = clr_reply_reg;
        macc_next      = macc_reg;
        pacc_next      = pacc_reg;
        sacc_next      = sacc_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        mult_next      = mult_reg;
        full_next      = full_reg;
        w_next         = w_reg;
        r_next         = r_reg;
        load_out       = 1'b0;
        tbl_wr         = '0;
        tbl_wr.addr    = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req.opcode;
                    key_next  = req.join_key;
                    mult_next = 32'd0;
                    full_next = 1'b0;
                    case (req.opcode)
                        OP_BUILD, OP_PROBE:
                        begin
                            state_next = ST_HASH0;
                        end
                        OP_CLEAR:
                        begin
                            macc_next      = 64'd0;
                            pacc_next      = 64'd0;
                            sacc_next      = 64'd0;
                            idx_next       = '0;
                            clr_reply_next = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                // one slot a cycle marked empty
                tbl_wr.en = 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = clr_reply_reg ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_HASH0:
            begin
                state_next = ST_HASH1;
            end
            ST_HASH1:
            begin
                state_next = ST_HASH2;
            end
            ST_HASH2:
            begin
                idx_next   = prod[32 +: IDX_W];
                n_next     = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!rd_data.valid)
                begin
                    // empty slot: insert on build, miss on probe
                    if (op_reg == OP_BUILD)
                    begin
                        tbl_wr.en         = 1'b1;
                        tbl_wr.data.valid = 1'b1;
                        tbl_wr.data.key   = key_reg;
                        tbl_wr.data.count = 32'd1;
                        mult_next         = 32'd1;
                    end
                    state_next = ST_DONE;
                end
                else if (rd_data.key == key_reg)
                begin
                    if (op_reg == OP_BUILD)
                    begin
                        tbl_wr.en         = 1'b1;
                        tbl_wr.data.valid = 1'b1;
                        tbl_wr.data.key   = key_reg;
                        tbl_wr.data.count = sat_cnt;
                        mult_next         = sat_cnt;
                        state_next        = ST_DONE;
                    end
                    else
                    begin
                        mult_next  = rd_data.count;
                        macc_next  = macc_reg + 64'(rd_data.count);
                        sel_next   = 1'b0;
                        state_next = ST_MIXI;
                    end
                end
                else if (n_reg == STEP_LAST)
                begin
                    // every slot visited
                    full_next  = (op_reg == OP_BUILD);
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
                    n_next     = n_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_MIXI:
            begin
                w_next     = mix_z ^ (mix_z >> 30);
                st_next    = 4'd0;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                st_next = st_reg + 4'd1;
                case (st_reg)
                    4'd1, 4'd5, 4'd9:
                    begin
                        r_next = prod;
                    end
                    4'd2, 4'd6, 4'd10:
                    begin
                        r_next = rr;
                    end
                    4'd3:
                    begin
                        w_next = rr ^ (rr >> 27);
                    end
                    4'd7:
                    begin
                        w_next = rr ^ (rr >> 31);
                    end
                    4'd11:
                    begin
                        if (sel_reg)
                        begin
                            sacc_next  = sacc_reg + r_reg;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            pacc_next  = pacc_reg + r_reg;
                            sel_next   = 1'b1;
                            state_next = ST_MIXI;
                        end
                    end
                    default:
                    begin
                        r_next = r_reg;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    assign out_valid_next = load_out | (out_valid_reg & ~rsp.ready);
    assign om_next        = load_out ? mult_reg : om_reg;
    assign ot_next        = load_out ? macc_reg : ot_reg;
    assign op_sum_next    = load_out ? pacc_reg : op_sum_reg;
    assign os_sum_next    = load_out ? sacc_reg : os_sum_reg;
    assign of_next        = load_out ? full_reg : of_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            n_reg         <= '0;
            st_reg        <= 4'd0;
            sel_reg       <= 1'b0;
            clr_reply_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            macc_reg      <= 64'd0;
            pacc_reg      <= 64'd0;
            sacc_reg      <= 64'd0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            st_reg        <= st_next;
            sel_reg       <= sel_next;
            clr_reply_reg <= clr_reply_next;
            out_valid_reg <= out_valid_next;
            macc_reg      <= macc_next;
            pacc_reg      <= pacc_next;
            sacc_reg      <= sacc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        mult_reg   <= mult_next;
        full_reg   <= full_next;
        w_reg      <= w_next;
        r_reg      <= r_next;
        om_reg     <= om_next;
        ot_reg     <= ot_next;
        op_sum_reg <= op_sum_next;
        os_sum_reg <= os_sum_next;
        of_reg     <= of_next;
    end

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.multiplicity = om_reg;
    assign rsp.match_total  = ot_reg;
    assign rsp.sum_plain    = op_sum_reg;
    assign rsp.sum_salted   = os_sum_reg;
    assign rsp.table_full   = of_reg;

    // checks
    `HJCC_ASSERT_IMP(a_full_no_mult, clk, rst_n, rsp.valid && rsp.table_full, rsp.multiplicity == 32'd0)
    `HJCC_ASSERT_NXT(a_accept_busy, clk, rst_n, req.valid && req.ready, state_reg != ST_IDLE)
    `HJCC_ASSERT_IMP(a_sweep_clears, clk, rst_n, state_reg == ST_CLEAR, tbl_wr.en && !tbl_wr.data.valid)
    `HJCC_ASSERT_IMP(a_search_bound, clk, rst_n, state_reg == ST_CMP, n_reg <= STEP_LAST)

endmodule

>>> design/hjcc_mul.sv
// Shared 32x32 multiplier with a registered 64-bit product.
// Depends on nothing; one product per cycle, result in the cycle after the operands.
module hjcc_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);
    logic [63:0] prod_reg;
    logic [63:0] prod_next;

    // full product of two unsigned words
    assign prod_next = 64'(a) * 64'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;
endmodule

>>> design/hjcc_table.sv
// Slot memory of the hash table: one write port, one registered read port.
// Depends on hjcc_pkg.
module hjcc_table (
    input  logic             clk,
    input  hjcc_pkg::idx_t   rd_addr,
    output hjcc_pkg::slot_t  rd_data,
    input  hjcc_pkg::tbl_wr_t wr
);
    import hjcc_pkg::*;

    slot_t mem [TABLE_ENTRIES];
    slot_t rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

>>> verif/hash_join_count_checksum_core_tb.sv
// Self-checking bench for the hash join core: builds, probes, clears and no-ops.
// Depends on hjcc_pkg, hjcc_req_if / hjcc_rsp_if and the core itself.
`timescale 1ns / 100ps

module hash_join_count_checksum_core_tb;
    import hjcc_pkg::*;

    localparam int IDLE_PCT   = 21;
    localparam int RAND_ITEMS = 600;
    localparam int HOLD_LEN   = 400;
    localparam int CYCLE_CAP  = 3000000;

    typedef struct {
        logic [31:0] mult;
        logic [63:0] match_sum;
        logic [63:0] plain;
        logic [63:0] salted;
        logic        full;
    } join_res_t;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] key;
        bit          typed;     // expectation written out below, totals zero
        logic [31:0] mult;
        logic        full;
    } stim_row_t;

    logic clk;
    logic rst_n;

    hjcc_req_if req_ch ();
    hjcc_rsp_if rsp_ch ();

    hash_join_count_checksum_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the slot table and the running totals
    bit          tab_valid [TABLE_ENTRIES];
    logic [63:0] tab_key [TABLE_ENTRIES];
    logic [31:0] tab_cnt [TABLE_ENTRIES];
    int          tab_used;
    logic [63:0] acc_match, acc_plain, acc_salted;

    join_res_t   pending_res[$];
    int          errors;
    int          beats_in, beats_out, hits_seen, full_seen;
    int          src_idle_pct, snk_idle_pct;
    int          cycle_cnt;
    bit          hold_done;
    int          hold_left;
    logic [63:0] key_pool[$];

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [63:0] splitmix(input logic [63:0] x);
        logic [63:0] z;
        z = x + GOLDEN;
        z = (z ^ (z >> 30)) * MIX_A;
        z = (z ^ (z >> 27)) * MIX_B;
        return z ^ (z >> 31);
    endfunction

    function automatic int home_of(input logic [63:0] key);
        logic [31:0] h;
        logic [63:0] p;
        h = (key[31:0] ^ key[63:32]) * HOME_MUL;
        p = {32'd0, h} * 64'(TABLE_ENTRIES);
        return int'(p >> 32);
    endfunction

    function automatic void table_clear();
        foreach (tab_valid[i]) tab_valid[i] = 1'b0;
        tab_used   = 0;
        acc_match  = '0;
        acc_plain  = '0;
        acc_salted = '0;
    endfunction

    // Apply one beat to the mirror and return what the core should answer
    function automatic join_res_t join_step(input logic [1:0] op, input logic [63:0] key);
        join_res_t r;
        int        idx;
        int        slot;
        bit        found;
        bit        has_free;
        found    = 1'b0;
        has_free = 1'b0;
        slot     = 0;
        r.mult   = '0;
        r.full   = 1'b0;
        if (op == OP_BUILD || op == OP_PROBE)
        begin
            idx = home_of(key);
            for (int n = 0; n < TABLE_ENTRIES; n++)
            begin
                if (idx >= TABLE_ENTRIES) idx = 0;
                if (!tab_valid[idx])
                begin
                    slot = idx;
                    has_free = 1'b1;
                    break;
                end
                if (tab_key[idx] == key)
                begin
                    slot = idx;
                    found = 1'b1;
                    break;
                end
                idx++;
            end
        end
        case (op)
            OP_BUILD:
            begin
                if (found)
                begin
                    if (tab_cnt[slot] != COUNT_MAX) tab_cnt[slot]++;
                    r.mult = tab_cnt[slot];
                end
                else if (has_free)
                begin
                    tab_valid[slot] = 1'b1;
                    tab_key[slot]   = key;
                    tab_cnt[slot]   = 32'd1;
                    tab_used++;
                    r.mult = 32'd1;
                end
                else
                begin
                    r.full = 1'b1;
                end
            end
            OP_PROBE:
            begin
                if (found)
                begin
                    r.mult     = tab_cnt[slot];
                    acc_match  += {32'd0, r.mult};
                    acc_plain  += splitmix(key) * {32'd0, r.mult};
                    acc_salted += splitmix(key ^ GOLDEN) * {32'd0, r.mult};
                end
            end
            OP_CLEAR: table_clear();
            default: ;
        endcase
        r.match_sum = acc_match;
        r.plain     = acc_plain;
        r.salted    = acc_salted;
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH beat %0d %s: got %h want %h", beats_out, what, got, want);
        errors++;
    endtask

    // Offer one beat, with a random gap in front, and hold it until taken
    task automatic send_beat(input stim_row_t row);
        join_res_t r;
        if ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        req_ch.valid    <= 1'b1;
        req_ch.opcode   <= row.op;
        req_ch.join_key <= row.key;
        do @(posedge clk); while (!req_ch.ready);
        r = join_step(row.op, row.key);
        if (row.typed)
        begin
            r.mult      = row.mult;
            r.full      = row.full;
            r.match_sum = '0;
            r.plain     = '0;
            r.salted    = '0;
        end
        pending_res.push_back(r);
        beats_in++;
    endtask

    function automatic stim_row_t mk(input logic [1:0] op, input logic [63:0] key,
                                     input bit typed = 0, input logic [31:0] mult = 0,
                                     input logic full = 0);
        stim_row_t s;
        s.op = op; s.key = key; s.typed = typed; s.mult = mult; s.full = full;
        return s;
    endfunction

    // Keys folding to one value share a home slot
    function automatic logic [63:0] twin_key(input logic [31:0] hi, input logic [31:0] fold);
        return {hi, hi ^ fold};
    endfunction

    // Response side: random back-pressure, one long hold, and the checks
    always @(posedge clk or negedge rst_n)
    begin
        join_res_t w;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_done    <= 1'b0;
            hold_left    <= 0;
        end
        else
        begin
            if (!hold_done && beats_in >= 100)
            begin
                hold_done    <= 1'b1;
                hold_left    <= HOLD_LEN;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_res.size() == 0)
                begin
                    report("response with nothing outstanding", 64'd0, 64'd0);
                end
                else
                begin
                    w = pending_res.pop_front();
                    if (rsp_ch.multiplicity !== w.mult)
                        report("multiplicity", 64'(rsp_ch.multiplicity), 64'(w.mult));
                    if (rsp_ch.match_total !== w.match_sum)
                        report("match_total", rsp_ch.match_total, w.match_sum);
                    if (rsp_ch.sum_plain !== w.plain)
                        report("sum_plain", rsp_ch.sum_plain, w.plain);
                    if (rsp_ch.sum_salted !== w.salted)
                        report("sum_salted", rsp_ch.sum_salted, w.salted);
                    if (rsp_ch.table_full !== w.full)
                        report("table_full", 64'(rsp_ch.table_full), 64'(w.full));
                    if (w.mult != 0 && w.full == 1'b0) hits_seen++;
                    if (w.full) full_seen++;
                end
                beats_out++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("timeout with %0d responses outstanding", pending_res.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   plan[$];
        stim_row_t   row;
        logic [63:0] ka, kb1, kb2, kb3, ones;
        int          pick;
        errors       = 0;
        beats_in     = 0;
        beats_out    = 0;
        hits_seen    = 0;
        full_seen    = 0;
        cycle_cnt    = 0;
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
        table_clear();
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.opcode   = OP_NOP;
        req_ch.join_key = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        ka   = 64'h0123_4567_89ab_cdef;
        ones = '1;
        kb1  = twin_key(32'h1111_0000, 32'h5a5a_0001);
        kb2  = twin_key(32'h2222_0000, 32'h5a5a_0001);
        kb3  = twin_key(32'h3333_0000, 32'h5a5a_0001);

        // Directed rows: totals stay zero until the first probe hit
        plan.push_back(mk(OP_PROBE, ka, 1, 0));
        plan.push_back(mk(OP_NOP, ones, 1, 0));
        plan.push_back(mk(OP_BUILD, ka, 1, 1));
        plan.push_back(mk(OP_BUILD, ka, 1, 2));
        plan.push_back(mk(OP_BUILD, '0, 1, 1));
        plan.push_back(mk(OP_BUILD, ones, 1, 1));
        plan.push_back(mk(OP_BUILD, kb1, 1, 1));
        plan.push_back(mk(OP_BUILD, kb2, 1, 1));
        plan.push_back(mk(OP_BUILD, kb3, 1, 1));
        plan.push_back(mk(OP_BUILD, kb2, 1, 2));
        plan.push_back(mk(OP_PROBE, 64'hdead_beef_0000_0001, 1, 0));
        plan.push_back(mk(OP_PROBE, ka));
        plan.push_back(mk(OP_PROBE, ones));
        plan.push_back(mk(OP_PROBE, '0));
        plan.push_back(mk(OP_PROBE, kb3));
        plan.push_back(mk(OP_PROBE, kb2));
        plan.push_back(mk(OP_PROBE, twin_key(32'h4444_0000, 32'h5a5a_0001)));
        plan.push_back(mk(OP_NOP, ka));
        plan.push_back(mk(OP_BUILD, ka));
        plan.push_back(mk(OP_CLEAR, ka, 1, 0));
        plan.push_back(mk(OP_PROBE, ka, 1, 0));
        plan.push_back(mk(OP_BUILD, ka, 1, 1));
        plan.push_back(mk(OP_PROBE, ka));
        foreach (plan[i]) send_beat(plan[i]);

        // Key pool: some keys sharing home slots, the rest anywhere
        for (int i = 0; i < 48; i++)
        begin
            if (i % 2 == 0)
                key_pool.push_back(twin_key($urandom(), 32'h0f0f_0000 + (i % 6)));
            else
                key_pool.push_back({$urandom(), $urandom()});
        end

        // Random part: mostly builds and probes over the pool
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == 250)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            else if (i == 350)
            begin
                src_idle_pct = IDLE_PCT;
                snk_idle_pct = IDLE_PCT;
            end
            pick = $urandom_range(99);
            if (pick < 45)       row.op = OP_BUILD;
            else if (pick < 90)  row.op = OP_PROBE;
            else if (pick < 93)  row.op = OP_CLEAR;
            else                 row.op = OP_NOP;
            if ($urandom_range(99) < 80)
                row.key = key_pool[$urandom_range(key_pool.size() - 1)];
            else
                row.key = {$urandom(), $urandom()};
            row.typed = 1'b0;
            send_beat(row);
        end

        // Fill the table to the last slot, then push on against a full table
        snk_idle_pct = 5;
        src_idle_pct = 5;
        while (tab_used < TABLE_ENTRIES)
            send_beat(mk(OP_BUILD, {$urandom(), $urandom()}));
        for (int i = 0; i < 4; i++)
        begin
            send_beat(mk(OP_BUILD, {$urandom(), $urandom()}));
            send_beat(mk(OP_PROBE, {$urandom(), $urandom()}));
        end
        send_beat(mk(OP_BUILD, tab_key[TABLE_ENTRIES - 1]));
        send_beat(mk(OP_PROBE, tab_key[0]));
        send_beat(mk(OP_CLEAR, '0));
        send_beat(mk(OP_PROBE, ka));
        send_beat(mk(OP_BUILD, ka));

        @(posedge clk);
        req_ch.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        $display("%0d beats in, %0d checked; %0d non-zero counts, %0d dropped on full table",
                 beats_in, beats_out, hits_seen, full_seen);
        $display("covered collisions, clears, no-ops, a long output hold and a filled table");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
